/* sv/msm_pkg.sv */
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types, codes and arithmetic helpers for the matrix slice multiplier.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam int OP_W      = 2;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 64;

  typedef logic [VAL_W-1:0] word_t;
  typedef logic [CFG_W-1:0] cfg_t;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_ROWS  = 1'b1;

  localparam cfg_t RESET_MATRIX_SIZE = 4'd8;
  localparam cfg_t RESET_SLICE_ROWS  = 4'd8;

  // clamp a 64-bit sum into signed 32 bits
  function automatic word_t saturate32(input logic signed [ACC_W-1:0] acc);
    word_t res;
    if (acc[ACC_W-1:VAL_W-1] == '0 || acc[ACC_W-1:VAL_W-1] == '1) begin
      res = acc[VAL_W-1:0];
    end else if (acc[ACC_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

/* sv/msm_ram.sv */
// ----------------------------------------------------------------------------
// msm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/matrix_slice_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_slice_multiply
// Multiplies a slice of rows of A by a square matrix B in signed Q16.16.
// ----------------------------------------------------------------------------
// A load item (operation 0 or 1) writes the next element of A or B, row-major;
// loads beyond a store's depth are dropped. A compute item (operation 2)
// rewinds both load pointers when it is accepted and emits
// C[i][j] = sum_k round(A[i][k]*B[k][j]) row-major, with out_last on the final
// element. One shared multiply-accumulate unit produces one term per cycle:
// each result element passes its n terms through the RAM read, multiply and
// accumulate stages, drains them, and is then handed off. A compute item keeps
// in_stall high from its acceptance until its last element is handed off,
// including while a waiting result holds back the next hand-off under out_stall.
// The stores hold no defined data until loaded; only read what was written.
// ----------------------------------------------------------------------------
module matrix_slice_multiply #(
  parameter int MAX_SIZE = 8,
  parameter int MAX_ROWS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [msm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [msm_pkg::OP_W-1:0]       in_operation,
  input  logic signed [msm_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [msm_pkg::VAL_W-1:0] out_product,
  output logic                           out_last
);

  localparam int A_DEPTH = MAX_ROWS * MAX_SIZE;
  localparam int B_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int A_PW    = $clog2(A_DEPTH + 1);
  localparam int B_PW    = $clog2(B_DEPTH + 1);
  localparam int CW      = msm_pkg::CFG_W;
  localparam int PW      = msm_pkg::ACC_W;

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [STATE_W-1:0] ST_RUN   = 2'd1;
  localparam logic [STATE_W-1:0] ST_DRAIN = 2'd2;
  localparam logic [STATE_W-1:0] ST_EMIT  = 2'd3;

  // configuration
  msm_pkg::cfg_t size_r, rows_r;
  msm_pkg::cfg_t n_eff, rows_eff;

  // sequencer
  logic [STATE_W-1:0] state_r, state_nxt;
  logic [A_PW-1:0]    a_ptr_r, a_ptr_nxt;
  logic [B_PW-1:0]    b_ptr_r, b_ptr_nxt;
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [A_AW-1:0]    row_base_r, row_base_nxt, a_addr_r, a_addr_nxt;
  logic [B_AW-1:0]    b_addr_r, b_addr_nxt;

  // datapath
  msm_pkg::word_t                    a_rdata, b_rdata;
  logic                              rd_v_r, prod_v_r;
  logic signed [msm_pkg::ACC_W-1:0]  prod_nxt, prod_r, term, acc_r;
  logic signed [msm_pkg::VAL_W-1:0]  a_s, b_s;
  logic                              out_valid_r, out_last_r;
  msm_pkg::word_t                    out_product_r;

  logic in_acc, is_compute, a_we, b_we, issue, emit, elem_last, row_end, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= msm_pkg::RESET_MATRIX_SIZE;
      rows_r <= msm_pkg::RESET_SLICE_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        msm_pkg::REG_MATRIX_SIZE: size_r <= cfg_wdata;
        msm_pkg::REG_SLICE_ROWS:  rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_eff    = (size_r > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : size_r;
  assign rows_eff = (rows_r > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_r;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign is_compute = in_acc && (in_operation == msm_pkg::OP_COMPUTE);
  assign a_we = in_acc && (in_operation == msm_pkg::OP_LOAD_A) && (a_ptr_r < A_PW'(A_DEPTH));
  assign b_we = in_acc && (in_operation == msm_pkg::OP_LOAD_B) && (b_ptr_r < B_PW'(B_DEPTH));
  assign issue     = (state_r == ST_RUN);
  assign out_take  = out_valid_r && !out_stall;
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign row_end   = (j_r == n_eff - CW'(1));
  assign elem_last = row_end && (i_r == rows_eff - CW'(1));

  always_comb begin
    state_nxt    = state_r;
    a_ptr_nxt    = a_ptr_r;
    b_ptr_nxt    = b_ptr_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    row_base_nxt = row_base_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (is_compute) begin
          a_ptr_nxt    = '0;
          b_ptr_nxt    = '0;
          i_nxt        = '0;
          j_nxt        = '0;
          k_nxt        = '0;
          row_base_nxt = '0;
          a_addr_nxt   = '0;
          b_addr_nxt   = '0;
          // empty problem: pointers and indexes are rewound, but no computation starts
          if (n_eff != '0 && rows_eff != '0) begin
            state_nxt = ST_RUN;
          end
        end else begin
          if (a_we) begin
            a_ptr_nxt = a_ptr_r + A_PW'(1);
          end
          if (b_we) begin
            b_ptr_nxt = b_ptr_r + B_PW'(1);
          end
        end
      end
      ST_RUN: begin
        a_addr_nxt = a_addr_r + A_AW'(1);
        b_addr_nxt = b_addr_r + B_AW'(n_eff);
        if (k_r == n_eff - CW'(1)) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else if (row_end) begin
            j_nxt        = '0;
            i_nxt        = i_r + CW'(1);
            row_base_nxt = row_base_r + A_AW'(n_eff);
            a_addr_nxt   = row_base_r + A_AW'(n_eff);
            b_addr_nxt   = '0;
            state_nxt    = ST_RUN;
          end else begin
            j_nxt      = j_r + CW'(1);
            a_addr_nxt = row_base_r;
            b_addr_nxt = B_AW'(j_r) + B_AW'(1);
            state_nxt  = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_ptr_r <= '0;
      b_ptr_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      a_ptr_r <= a_ptr_nxt;
      b_ptr_r <= b_ptr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
  end

  msm_ram #(.WIDTH(msm_pkg::VAL_W), .DEPTH(A_DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_ptr_r[A_AW-1:0]),
    .wdata (in_value),
    .raddr (a_addr_r),
    .rdata (a_rdata)
  );

  msm_ram #(.WIDTH(msm_pkg::VAL_W), .DEPTH(B_DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_ptr_r[B_AW-1:0]),
    .wdata (in_value),
    .raddr (b_addr_r),
    .rdata (b_rdata)
  );

  // shared MAC: RAM read -> product register -> round and accumulate
  assign a_s      = a_rdata;
  assign b_s      = b_rdata;
  assign prod_nxt = PW'(a_s) * PW'(b_s);
  assign term     = (prod_r + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (emit || is_compute) begin
        acc_r <= '0;
      end else if (prod_v_r) begin
        acc_r <= acc_r + term;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_product_r <= msm_pkg::saturate32(acc_r);
      out_last_r    <= elem_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_last    = out_last_r;

  // the MAC pipeline is empty whenever a new item may enter
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!rd_v_r && !prod_v_r))
    else $error("MAC pipeline busy while accepting items");

  // a result is only handed off after every term was accumulated
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (!rd_v_r && !prod_v_r))
    else $error("result taken before accumulation finished");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_ptr_r <= A_PW'(A_DEPTH)) && (b_ptr_r <= B_PW'(B_DEPTH)))
    else $error("load pointer beyond store depth");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r < n_eff && j_r < n_eff && i_r < rows_eff))
    else $error("term index out of range");

endmodule
